FILE: hw/rtl/oqrk_pkg.sv
// Shared constants, codes and types for the ordered queue with keyed removal.
package oqrk_pkg;

   localparam int KEY_BITS         = 16;
   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_PAYLOAD_BITS = 32;

   localparam logic REQ_PUSH    = 1'b0;
   localparam logic REQ_EXTRACT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

FILE: hw/rtl/ordered_queue_remove_by_key.sv
// Top level of the ordered queue with keyed removal.
//
//   channel  direction  transfer when          carries
//   req      in         req_valid & !req_stall  req_type, req_item_key, req_item_payload
//   rsp      out        rsp_valid & !rsp_stall  rsp_status, rsp_found_key,
//                                               rsp_found_payload, rsp_entry_count
//
// A push, or an extract on an empty queue, goes from ST_IDLE to ST_DONE, where its result
// loads; an extract on a non-empty queue first passes through ST_SCAN, which reads and
// compacts the held entries through the single read port of the record memory, one entry per cycle.
// A new request can be taken in the cycle after the result loads.
// Reset clears the entry count, sequencer and result valid; the memory is not cleared.
// A stalled result holds; one further request is taken and run meanwhile,
// and its result waits until the output register frees.
module ordered_queue_remove_by_key import oqrk_pkg::*; #(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic [KEY_BITS-1:0]     req_item_key,
   input  logic [PAYLOAD_BITS-1:0] req_item_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [KEY_BITS-1:0]     rsp_found_key,
   output logic [PAYLOAD_BITS-1:0] rsp_found_payload,
   output logic [CW-1:0]           rsp_entry_count
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int DW = KEY_BITS + PAYLOAD_BITS;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [DW-1:0] mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [DW-1:0] mem_rd_data;

   oqrk_ctrl #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_item_key      (req_item_key),
      .req_item_payload  (req_item_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_key     (rsp_found_key),
      .rsp_found_payload (rsp_found_payload),
      .rsp_entry_count   (rsp_entry_count),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   oqrk_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DATA_BITS   (DW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

FILE: hw/rtl/oqrk_mem.sv
// Record memory: one write port, one read port with registered read data.
module oqrk_mem import oqrk_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int DATA_BITS   = KEY_BITS + DEF_PAYLOAD_BITS,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/oqrk_ctrl.sv
// Request sequencer: push, scan-and-compact extract, and result register.
module oqrk_ctrl import oqrk_pkg::*; #(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CW = $clog2(QUEUE_DEPTH + 1),
   localparam int DW = KEY_BITS + PAYLOAD_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic [KEY_BITS-1:0]     req_item_key,
   input  logic [PAYLOAD_BITS-1:0] req_item_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [KEY_BITS-1:0]     rsp_found_key,
   output logic [PAYLOAD_BITS-1:0] rsp_found_payload,
   output logic [CW-1:0]           rsp_entry_count,
   output logic                    mem_wr_en,
   output logic [AW-1:0]           mem_wr_addr,
   output logic [DW-1:0]           mem_wr_data,
   output logic                    mem_rd_en,
   output logic [AW-1:0]           mem_rd_addr,
   input  logic [DW-1:0]           mem_rd_data
);

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           rd_ff, rd_in;
   logic [CW-1:0]           wr_ff, wr_in;
   logic                    hit_ff, hit_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [KEY_BITS-1:0]     fkey_ff, fkey_in;
   logic [PAYLOAD_BITS-1:0] fpay_ff, fpay_in;
   status_type              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]     rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff, rsp_pay_in;
   logic [CW-1:0]           rsp_count_ff, rsp_count_in;

   logic [KEY_BITS-1:0]     rd_key;
   logic [PAYLOAD_BITS-1:0] rd_pay;
   logic                    rsp_free;

   assign rd_key   = mem_rd_data[DW-1 -: KEY_BITS];
   assign rd_pay   = mem_rd_data[PAYLOAD_BITS-1:0];
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff         <= rd_in;
      wr_ff         <= wr_in;
      hit_ff        <= hit_in;
      key_ff        <= key_in;
      fkey_ff       <= fkey_in;
      fpay_ff       <= fpay_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      hit_in        = hit_ff;
      key_in        = key_ff;
      fkey_in       = fkey_ff;
      fpay_in       = fpay_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[AW-1:0];
      mem_wr_data   = {req_item_key, req_item_payload};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      req_stall     = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fkey_in = '0;
               fpay_in = '0;
               if (req_type == REQ_PUSH) begin
                  state_in = ST_DONE;
                  if (count_ff != CW'(QUEUE_DEPTH)) begin
                     mem_wr_en     = 1'b1;
                     count_in      = count_ff + CW'(1);
                     res_status_in = STATUS_OK;
                  end else begin
                     res_status_in = STATUS_FULL;
                  end
               end else begin
                  key_in = req_item_key;
                  hit_in = 1'b0;
                  wr_in  = '0;
                  if (count_ff == '0) begin
                     res_status_in = STATUS_MISS;
                     state_in      = ST_DONE;
                  end else begin
                     mem_rd_en = 1'b1;
                     rd_in     = CW'(1);
                     state_in  = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // writes land at or below the entry whose read data is now on mem_rd_data
            if (rd_key == key_ff) begin
               hit_in  = 1'b1;
               fkey_in = rd_key;
               fpay_in = rd_pay;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_ff[AW-1:0];
               mem_wr_data = mem_rd_data;
               wr_in       = wr_ff + CW'(1);
            end
            if (rd_ff != count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_ff[AW-1:0];
               rd_in       = rd_ff + CW'(1);
            end else begin
               count_in      = wr_in;
               res_status_in = hit_in ? STATUS_OK : STATUS_MISS;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = fkey_ff;
               rsp_pay_in    = fpay_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_key     = rsp_key_ff;
   assign rsp_found_payload = rsp_pay_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

FILE: hw/rtl/oqrk_chk.sv
// Port-level checker for the ordered queue, bound to the top level.
module oqrk_chk import oqrk_pkg::*; #(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [1:0]              rsp_status,
   input logic [KEY_BITS-1:0]     rsp_found_key,
   input logic [PAYLOAD_BITS-1:0] rsp_found_payload,
   input logic [CW-1:0]           rsp_entry_count
);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= CW'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |->
         (rsp_found_key == '0 && rsp_found_payload == '0 &&
          rsp_entry_count == CW'(QUEUE_DEPTH)))
      else $error("dropped push result malformed");

   a_miss_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_MISS) |->
         (rsp_found_key == '0 && rsp_found_payload == '0))
      else $error("not-found result carries a record");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FULL ||
                     rsp_status == STATUS_MISS))
      else $error("undefined status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_found_key) &&
          $stable(rsp_found_payload) && $stable(rsp_entry_count)))
      else $error("stalled result changed");

endmodule

bind ordered_queue_remove_by_key oqrk_chk #(
   .QUEUE_DEPTH  (QUEUE_DEPTH),
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_oqrk_chk (.*);

FILE: test/ordered_queue_remove_by_key_test.sv
// Testbench for the ordered queue with keyed removal: directed, random and backpressure.
`timescale 1ns / 100ps

module ordered_queue_remove_by_key_test;
   import oqrk_pkg::*;

   localparam int DEPTH          = DEF_QUEUE_DEPTH;
   localparam int PBITS          = DEF_PAYLOAD_BITS;
   localparam int CW             = $clog2(DEPTH + 1);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = DEPTH + 4;
   localparam int HOLD_OFF_CYCLES = 200;

   typedef struct {
      status_type            status;
      logic [KEY_BITS-1:0]   key;
      logic [PBITS-1:0]      payload;
      logic [CW-1:0]         count;
   } queue_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_type = REQ_PUSH;
   logic [KEY_BITS-1:0] req_item_key = '0;
   logic [PBITS-1:0]    req_item_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [KEY_BITS-1:0] rsp_found_key;
   logic [PBITS-1:0]    rsp_found_payload;
   logic [CW-1:0]       rsp_entry_count;

   logic [KEY_BITS-1:0] shadow_keys[$];
   logic [PBITS-1:0]    shadow_payloads[$];
   queue_result_type    results_due[$];

   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off_left  = 0;

   always #5 clock = ~clock;

   ordered_queue_remove_by_key dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_item_key      (req_item_key),
      .req_item_payload  (req_item_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_key     (rsp_found_key),
      .rsp_found_payload (rsp_found_payload),
      .rsp_entry_count   (rsp_entry_count)
   );

   function automatic queue_result_type apply_request(logic kind, logic [KEY_BITS-1:0] key,
                                                      logic [PBITS-1:0] payload);
      queue_result_type    r;
      logic [KEY_BITS-1:0] kept_keys[$];
      logic [PBITS-1:0]    kept_payloads[$];
      bit                  hit;
      r.status  = STATUS_OK;
      r.key     = '0;
      r.payload = '0;
      hit       = 1'b0;
      if (kind == REQ_PUSH) begin
         if (shadow_keys.size() >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            shadow_keys.push_back(key);
            shadow_payloads.push_back(payload);
         end
      end else begin
         foreach (shadow_keys[i]) begin
            if (shadow_keys[i] == key) begin
               hit       = 1'b1;
               r.key     = shadow_keys[i];
               r.payload = shadow_payloads[i];
            end else begin
               kept_keys.push_back(shadow_keys[i]);
               kept_payloads.push_back(shadow_payloads[i]);
            end
         end
         shadow_keys     = kept_keys;
         shadow_payloads = kept_payloads;
         if (!hit)
            r.status = STATUS_MISS;
      end
      r.count = CW'(shadow_keys.size());
      return r;
   endfunction

   task automatic send_request(logic kind, logic [KEY_BITS-1:0] key, logic [PBITS-1:0] payload);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_item_key     <= key;
      req_item_payload <= payload;
      do @(posedge clock); while (req_stall);
      results_due.push_back(apply_request(kind, key, payload));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_extract_empty();
      send_request(REQ_EXTRACT, 16'h0000, 32'hFFFF_FFFF);
      wait_drain();
   endtask

   task automatic test_fill_to_full();
      send_request(REQ_PUSH, 16'h0000, 32'h0000_0000);
      send_request(REQ_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < DEPTH - 2; i++)
         send_request(REQ_PUSH, (i % 2) ? 16'h0005 : 16'h0007, PBITS'($urandom));
      send_request(REQ_PUSH, 16'hAAAA, 32'h5555_5555);
      wait_drain();
   endtask

   task automatic test_multi_match_extract();
      send_request(REQ_EXTRACT, 16'h0005, 32'h0000_0000);
      send_request(REQ_EXTRACT, 16'hFFFF, 32'h0000_0000);
      wait_drain();
   endtask

   task automatic test_key_miss();
      send_request(REQ_EXTRACT, 16'h0005, 32'hFFFF_FFFF);
      send_request(REQ_EXTRACT, 16'h1234, 32'h0000_0000);
      send_request(REQ_EXTRACT, 16'h0000, 32'h0000_0000);
      wait_drain();
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int count, int push_pct);
      logic [KEY_BITS-1:0] key;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         case ($urandom_range(7))
            0: key = KEY_BITS'($urandom);
            1: key = 16'hFFF8 | KEY_BITS'($urandom_range(7));
            default: key = KEY_BITS'($urandom_range(7));
         endcase
         send_request(($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_EXTRACT, key,
                      PBITS'($urandom));
      end
      wait_drain();
   endtask

   task automatic test_input_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_left  = HOLD_OFF_CYCLES;
      repeat (24)
         send_request(($urandom_range(3) != 0) ? REQ_PUSH : REQ_EXTRACT,
                      KEY_BITS'($urandom_range(3)), PBITS'($urandom));
      wait_drain();
   endtask

   // hold off for a counted stretch, else stall at random
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin
      queue_result_type due;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               error_count++;
               $error("result transfer with none due: status %0d", rsp_status);
            end else begin
               due = results_due.pop_front();
               if (rsp_status != due.status) begin
                  error_count++;
                  $error("status: expected %0d, actual %0d", due.status, rsp_status);
               end
               if (rsp_found_key != due.key) begin
                  error_count++;
                  $error("found_key: expected %h, actual %h", due.key, rsp_found_key);
               end
               if (rsp_found_payload != due.payload) begin
                  error_count++;
                  $error("found_payload: expected %h, actual %h", due.payload,
                         rsp_found_payload);
               end
               if (rsp_entry_count != due.count) begin
                  error_count++;
                  $error("entry_count: expected %0d, actual %0d", due.count,
                         rsp_entry_count);
               end
            end
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_extract_empty();
      test_fill_to_full();
      test_multi_match_extract();
      test_key_miss();
      test_random_traffic(0, 0, 120, 80);
      test_random_traffic(51, 0, 120, 60);
      test_random_traffic(0, 51, 120, 80);
      test_random_traffic(37, 37, 120, 60);
      test_input_backpressure();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
